### src/vna_pkg.sv
// shared types and constants of the vertex normal accumulator
package vna_pkg;

    localparam logic [1:0] OP_LOAD = 2'd0;
    localparam logic [1:0] OP_TRI  = 2'd1;
    localparam logic [1:0] OP_READ = 2'd2;
    localparam logic [1:0] OP_NOP  = 2'd3;

    localparam logic STAT_OK      = 1'b0;
    localparam logic STAT_REFUSED = 1'b1;

    localparam logic REG_PARTIAL = 1'b0;

    localparam int NORM_BITS = 30;
    localparam int QUOT_BITS = 16;
    localparam logic [15:0] OUT_MAX = 16'h7fff;

    typedef struct packed {
        logic [1:0]         operation;
        logic [9:0]         vertex_a;
        logic [9:0]         vertex_b;
        logic [9:0]         vertex_c;
        logic signed [23:0] pos_x;
        logic signed [23:0] pos_y;
        logic signed [23:0] pos_z;
    } item_t;

    typedef struct packed {
        logic signed [15:0] normal_x;
        logic signed [15:0] normal_y;
        logic signed [15:0] normal_z;
        logic               status;
    } result_t;

endpackage

### src/vna_ram.sv
// generic single write port ram with registered read
module vna_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

### src/vna_mul.sv
// shared registered signed multiplier
module vna_mul #(
    parameter int W = 31
) (
    input  logic                  clk,
    input  logic signed [W-1:0]   a,
    input  logic signed [W-1:0]   b,
    output logic signed [2*W-1:0] p
);

    always_ff @(posedge clk)
    begin
        p <= a * b;
    end

endmodule

### src/vertex_normal_accumulate.sv
// top level: sequencer, datapath and register port of the vertex normal accumulator
//
//  channel   | signals                                  | handshake
//  ----------+------------------------------------------+---------------------------
//  item in   | start, busy, item                        | taken when start & !busy
//  result    | done, result                             | one cycle strobe, no stall
//  config    | psel penable pwrite paddr pwdata prdata  | apb, pready always high
//
//  a load or refused read ends in the dispatch state; triangle and read are paced by the shared
//  multiplier, a read also by the shift of the largest sum (up to 26 steps), the bit-serial
//  square root (32 steps) and three 16-step divisions
//  reset clears the sequencer, the strobe and the config register; memories undefined
//  busy stays high until the item is finished; results cannot be held off
module vertex_normal_accumulate #(
    parameter int MAX_VERTICES = 1024,
    parameter int POS_WIDTH    = 24,
    parameter int SUM_WIDTH    = 56
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            start,
    input  vna_pkg::item_t  item,
    output logic            busy,
    output logic            done,
    output vna_pkg::result_t result,
    input  logic            psel,
    input  logic            penable,
    input  logic            pwrite,
    input  logic [2:0]      paddr,
    input  logic [31:0]     pwdata,
    output logic [31:0]     prdata,
    output logic            pready
);

    localparam int AW  = $clog2(MAX_VERTICES);
    localparam int PW  = POS_WIDTH;
    localparam int SW  = SUM_WIDTH;
    localparam int DW  = PW + 1;
    localparam int MW  = (DW > 31) ? DW : 31;
    localparam int PRW = 2 * MW;
    localparam int XW  = (PRW + 1 > SW + 1) ? PRW + 1 : SW + 1;
    localparam int NB  = vna_pkg::NORM_BITS;
    localparam int QB  = vna_pkg::QUOT_BITS;

    localparam logic signed [SW-1:0] SUM_HI = {1'b0, {(SW-1){1'b1}}};
    localparam logic signed [SW-1:0] SUM_LO = {1'b1, {(SW-1){1'b0}}};

    typedef enum logic [14:0] {
        S_IDLE   = 15'b000000000000001,
        S_DISP   = 15'b000000000000010,
        S_TRD    = 15'b000000000000100,
        S_TMUL   = 15'b000000000001000,
        S_ARD    = 15'b000000000010000,
        S_ALD    = 15'b000000000100000,
        S_AADD   = 15'b000000001000000,
        S_AWR    = 15'b000000010000000,
        S_RRD    = 15'b000000100000000,
        S_RSHF   = 15'b000001000000000,
        S_RSQ    = 15'b000010000000000,
        S_RROOT  = 15'b000100000000000,
        S_RDINIT = 15'b001000000000000,
        S_RDIV   = 15'b010000000000000,
        S_RSTORE = 15'b100000000000000
    } state_t;

    state_t state_reg, state_next;
    logic [4:0] cnt_reg, cnt_next;
    logic [1:0] vsel_reg, vsel_next;
    vna_pkg::item_t item_reg, item_next;
    logic partial_reg;

    logic signed [PW-1:0]  pa_reg [3];
    logic signed [PW-1:0]  pa_next [3];
    logic signed [DW-1:0]  e1_reg [3];
    logic signed [DW-1:0]  e1_next [3];
    logic signed [DW-1:0]  e2_reg [3];
    logic signed [DW-1:0]  e2_next [3];
    logic signed [PRW-1:0] p_reg, p_next;
    logic signed [SW-1:0]  cr_reg [3];
    logic signed [SW-1:0]  cr_next [3];
    logic signed [SW-1:0]  sum_reg [3];
    logic signed [SW-1:0]  sum_next [3];
    logic [SW-1:0]         mag_reg [3];
    logic [SW-1:0]         mag_next [3];
    logic [2:0]            neg_reg, neg_next;
    logic [63:0]           len_reg, len_next;
    logic [63:0]           root_reg, root_next;
    logic [63:0]           bit_reg, bit_next;
    logic [31:0]           rem_reg, rem_next;
    logic [QB-1:0]         low_reg, low_next;
    logic [QB-1:0]         q_reg, q_next;
    logic [15:0]           out_reg [2];
    logic [15:0]           out_next [2];
    logic                  done_reg, done_next;
    vna_pkg::result_t      result_reg, result_next;

    logic signed [MW-1:0]  mul_a, mul_b;
    logic signed [PRW-1:0] mul_p;

    logic [AW-1:0]         rd_addr, wr_addr;
    logic                  pos_we, sum_we;
    logic [3*PW-1:0]       pos_wdata, pos_rdata;
    logic [3*SW-1:0]       sum_wdata, sum_rdata;

    logic signed [PW-1:0]  pos_unp [3];
    logic signed [SW-1:0]  sum_unp [3];

    function automatic logic [AW-1:0] to_addr(input logic [9:0] v);
        logic [31:0] w;
        w = 32'(v);
        return w[AW-1:0];
    endfunction

    function automatic logic in_range(input logic [9:0] v);
        return 32'(v) < 32'(MAX_VERTICES);
    endfunction

    function automatic logic [PW-1:0] pos_bits(input logic [23:0] raw);
        logic [31:0] w;
        w = 32'(raw);
        return w[PW-1:0];
    endfunction

    function automatic logic [9:0] corner(input vna_pkg::item_t it, input logic [1:0] sel);
        logic [9:0] v;
        case (sel)
            2'd0:    v = it.vertex_a;
            2'd1:    v = it.vertex_b;
            default: v = it.vertex_c;
        endcase
        return v;
    endfunction

    vna_ram #(.WIDTH(3 * PW), .DEPTH(MAX_VERTICES)) u_pos_ram (
        .clk   (clk),
        .we    (pos_we),
        .waddr (wr_addr),
        .wdata (pos_wdata),
        .raddr (rd_addr),
        .rdata (pos_rdata)
    );

    vna_ram #(.WIDTH(3 * SW), .DEPTH(MAX_VERTICES)) u_sum_ram (
        .clk   (clk),
        .we    (sum_we),
        .waddr (wr_addr),
        .wdata (sum_wdata),
        .raddr (rd_addr),
        .rdata (sum_rdata)
    );

    vna_mul #(.W(MW)) u_mul (
        .clk (clk),
        .a   (mul_a),
        .b   (mul_b),
        .p   (mul_p)
    );

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            pos_unp[i] = pos_rdata[i*PW +: PW];
            sum_unp[i] = sum_rdata[i*SW +: SW];
        end
    end

    assign busy   = (state_reg != S_IDLE);
    assign done   = done_reg;
    assign result = result_reg;
    assign pready = 1'b1;
    assign prdata = (paddr[2] == vna_pkg::REG_PARTIAL) ? {31'd0, partial_reg} : 32'd0;

    always_comb
    begin
        logic signed [XW-1:0] xd;
        logic signed [SW:0]   acc;
        logic [63:0]          t;
        logic [45:0]          num;
        logic [32:0]          tt;
        logic [QB-1:0]        qv;
        logic [15:0]          val;
        logic [1:0]           ci;

        state_next  = state_reg;
        cnt_next    = cnt_reg;
        vsel_next   = vsel_reg;
        item_next   = item_reg;
        pa_next     = pa_reg;
        e1_next     = e1_reg;
        e2_next     = e2_reg;
        p_next      = p_reg;
        cr_next     = cr_reg;
        sum_next    = sum_reg;
        mag_next    = mag_reg;
        neg_next    = neg_reg;
        len_next    = len_reg;
        root_next   = root_reg;
        bit_next    = bit_reg;
        rem_next    = rem_reg;
        low_next    = low_reg;
        q_next      = q_reg;
        out_next    = out_reg;
        done_next   = 1'b0;
        result_next = result_reg;

        mul_a     = '0;
        mul_b     = '0;
        rd_addr   = to_addr(item_reg.vertex_a);
        wr_addr   = to_addr(item_reg.vertex_a);
        pos_we    = 1'b0;
        sum_we    = 1'b0;
        pos_wdata = {pos_bits(item_reg.pos_z), pos_bits(item_reg.pos_y),
                     pos_bits(item_reg.pos_x)};
        sum_wdata = {sum_reg[2], sum_reg[1], sum_reg[0]};

        xd  = '0;
        acc = '0;
        t   = '0;
        num = '0;
        tt  = '0;
        qv  = '0;
        val = '0;
        ci  = '0;

        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    item_next  = item;
                    state_next = S_DISP;
                end
            end
            S_DISP:
            begin
                state_next = S_IDLE;
                case (item_reg.operation)
                    vna_pkg::OP_LOAD:
                    begin
                        pos_we    = in_range(item_reg.vertex_a);
                        sum_we    = in_range(item_reg.vertex_a);
                        sum_wdata = '0;
                    end
                    vna_pkg::OP_TRI:
                    begin
                        if (!partial_reg && in_range(item_reg.vertex_a)
                            && in_range(item_reg.vertex_b) && in_range(item_reg.vertex_c))
                        begin
                            cnt_next   = '0;
                            state_next = S_TRD;
                        end
                    end
                    vna_pkg::OP_READ:
                    begin
                        result_next = '0;
                        if (partial_reg)
                        begin
                            result_next.status = vna_pkg::STAT_REFUSED;
                            done_next          = 1'b1;
                        end
                        else if (!in_range(item_reg.vertex_a))
                        begin
                            result_next.status = vna_pkg::STAT_OK;
                            done_next          = 1'b1;
                        end
                        else
                        begin
                            state_next = S_RRD;
                        end
                    end
                    default:
                    begin
                        state_next = S_IDLE;
                    end
                endcase
            end
            S_TRD:
            begin
                cnt_next = cnt_reg + 5'd1;
                if (cnt_reg == 5'd0)
                begin
                    pa_next = pos_unp;
                    rd_addr = to_addr(item_reg.vertex_b);
                end
                else if (cnt_reg == 5'd1)
                begin
                    for (int i = 0; i < 3; i++)
                        e1_next[i] = DW'(pos_unp[i]) - DW'(pa_reg[i]);
                    rd_addr = to_addr(item_reg.vertex_c);
                end
                else
                begin
                    for (int i = 0; i < 3; i++)
                        e2_next[i] = DW'(pos_unp[i]) - DW'(pa_reg[i]);
                    cnt_next   = '0;
                    state_next = S_TMUL;
                end
            end
            S_TMUL:
            begin
                case (cnt_reg[2:0])
                    3'd0:    begin mul_a = MW'(e1_reg[1]); mul_b = MW'(e2_reg[2]); end
                    3'd1:    begin mul_a = MW'(e1_reg[2]); mul_b = MW'(e2_reg[1]); end
                    3'd2:    begin mul_a = MW'(e1_reg[2]); mul_b = MW'(e2_reg[0]); end
                    3'd3:    begin mul_a = MW'(e1_reg[0]); mul_b = MW'(e2_reg[2]); end
                    3'd4:    begin mul_a = MW'(e1_reg[0]); mul_b = MW'(e2_reg[1]); end
                    3'd5:    begin mul_a = MW'(e1_reg[1]); mul_b = MW'(e2_reg[0]); end
                    default: begin mul_a = '0; mul_b = '0; end
                endcase
                if (cnt_reg != 5'd0)
                begin
                    if (cnt_reg[0])
                    begin
                        p_next = mul_p;
                    end
                    else
                    begin
                        xd = XW'(p_reg) - XW'(mul_p);
                        ci = cnt_reg[2:1] - 2'd1;
                        if (xd > XW'(SUM_HI))
                            cr_next[ci] = SUM_HI;
                        else if (xd < XW'(SUM_LO))
                            cr_next[ci] = SUM_LO;
                        else
                            cr_next[ci] = xd[SW-1:0];
                    end
                end
                cnt_next = cnt_reg + 5'd1;
                if (cnt_reg == 5'd6)
                begin
                    vsel_next  = 2'd0;
                    state_next = S_ARD;
                end
            end
            S_ARD:
            begin
                rd_addr    = to_addr(corner(item_reg, vsel_reg));
                state_next = S_ALD;
            end
            S_ALD:
            begin
                sum_next   = sum_unp;
                cnt_next   = '0;
                state_next = S_AADD;
            end
            S_AADD:
            begin
                ci  = cnt_reg[1:0];
                acc = (SW+1)'(sum_reg[ci]) + (SW+1)'(cr_reg[ci]);
                if (acc[SW] != acc[SW-1])
                    sum_next[ci] = acc[SW] ? SUM_LO : SUM_HI;
                else
                    sum_next[ci] = acc[SW-1:0];
                cnt_next = cnt_reg + 5'd1;
                if (cnt_reg == 5'd2)
                    state_next = S_AWR;
            end
            S_AWR:
            begin
                wr_addr = to_addr(corner(item_reg, vsel_reg));
                sum_we  = 1'b1;
                if (vsel_reg == 2'd2)
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    vsel_next  = vsel_reg + 2'd1;
                    state_next = S_ARD;
                end
            end
            S_RRD:
            begin
                for (int i = 0; i < 3; i++)
                begin
                    neg_next[i] = sum_unp[i][SW-1];
                    mag_next[i] = sum_unp[i][SW-1] ? (~sum_unp[i] + 1'b1) : sum_unp[i];
                end
                state_next = S_RSHF;
            end
            S_RSHF:
            begin
                if ((|mag_reg[0][SW-1:NB]) || (|mag_reg[1][SW-1:NB])
                    || (|mag_reg[2][SW-1:NB]))
                begin
                    for (int i = 0; i < 3; i++)
                        mag_next[i] = mag_reg[i] >> 1;
                end
                else
                begin
                    len_next   = '0;
                    cnt_next   = '0;
                    state_next = S_RSQ;
                end
            end
            S_RSQ:
            begin
                if (cnt_reg != 5'd3)
                begin
                    mul_a = MW'(mag_reg[cnt_reg[1:0]][NB-1:0]);
                    mul_b = MW'(mag_reg[cnt_reg[1:0]][NB-1:0]);
                end
                if (cnt_reg != 5'd0)
                    len_next = len_reg + 64'(mul_p);
                cnt_next = cnt_reg + 5'd1;
                if (cnt_reg == 5'd3)
                begin
                    root_next  = '0;
                    bit_next   = 64'd1 << 62;
                    state_next = S_RROOT;
                end
            end
            S_RROOT:
            begin
                t = root_reg + bit_reg;
                if (len_reg >= t)
                begin
                    len_next  = len_reg - t;
                    root_next = (root_reg >> 1) + bit_reg;
                end
                else
                begin
                    root_next = root_reg >> 1;
                end
                bit_next = bit_reg >> 2;
                if (bit_reg[0])
                begin
                    vsel_next  = 2'd0;
                    state_next = S_RDINIT;
                end
            end
            S_RDINIT:
            begin
                num        = {1'b0, mag_reg[vsel_reg][NB-1:0], 15'd0}
                           + 46'(root_reg[31:1]);
                rem_next   = 32'(num[45:QB]);
                low_next   = num[QB-1:0];
                q_next     = '0;
                cnt_next   = '0;
                state_next = S_RDIV;
            end
            S_RDIV:
            begin
                tt = {rem_reg, low_reg[QB-1]};
                if (tt >= {1'b0, root_reg[31:0]})
                begin
                    tt     = tt - {1'b0, root_reg[31:0]};
                    q_next = {q_reg[QB-2:0], 1'b1};
                end
                else
                begin
                    q_next = {q_reg[QB-2:0], 1'b0};
                end
                rem_next = tt[31:0];
                low_next = low_reg << 1;
                cnt_next = cnt_reg + 5'd1;
                if (cnt_reg == 5'(QB - 1))
                    state_next = S_RSTORE;
            end
            S_RSTORE:
            begin
                qv = (root_reg == 64'd0) ? '0 : q_reg;
                if (neg_reg[vsel_reg])
                    val = 16'd0 - 16'(qv);
                else
                    val = (16'(qv) > vna_pkg::OUT_MAX) ? vna_pkg::OUT_MAX : 16'(qv);
                if (vsel_reg == 2'd2)
                begin
                    result_next.normal_x = out_reg[0];
                    result_next.normal_y = out_reg[1];
                    result_next.normal_z = val;
                    result_next.status   = vna_pkg::STAT_OK;
                    done_next            = 1'b1;
                    state_next           = S_IDLE;
                end
                else
                begin
                    out_next[vsel_reg[0]] = val;
                    vsel_next             = vsel_reg + 2'd1;
                    state_next            = S_RDINIT;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            done_reg    <= 1'b0;
            partial_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
            if (psel && penable && pwrite && (paddr[2] == vna_pkg::REG_PARTIAL))
            begin
                partial_reg <= pwdata[0];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        cnt_reg    <= cnt_next;
        vsel_reg   <= vsel_next;
        item_reg   <= item_next;
        pa_reg     <= pa_next;
        e1_reg     <= e1_next;
        e2_reg     <= e2_next;
        p_reg      <= p_next;
        cr_reg     <= cr_next;
        sum_reg    <= sum_next;
        mag_reg    <= mag_next;
        neg_reg    <= neg_next;
        len_reg    <= len_next;
        root_reg   <= root_next;
        bit_reg    <= bit_next;
        rem_reg    <= rem_next;
        low_reg    <= low_next;
        q_reg      <= q_next;
        out_reg    <= out_next;
        result_reg <= result_next;
    end

`ifndef ASSERT_OFF
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("item accepted but block not busy");

    a_done_after_work: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(busy))
        else $error("result without an item in progress");

    a_refused_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && result.status) |->
            (result.normal_x == 16'd0 && result.normal_y == 16'd0
             && result.normal_z == 16'd0))
        else $error("refused read carries a nonzero normal");

    a_no_write_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (pos_we || sum_we) |-> busy)
        else $error("memory write while idle");
`endif

endmodule
